// ===== src/lcs3_pkg.sv =====
// Shared types and constants for the three-sequence LCS length unit.
package lcs3_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned LenW  = 7;

  typedef enum logic [1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_APPEND_B = 2'd1,
    ACT_APPEND_C = 2'd2,
    ACT_COMPUTE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    action_e                  action;
    logic signed [ElemW-1:0]  element_value;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] lcs_length;
    logic            overflow;
  } result_t;

  typedef struct packed {
    logic append;
    logic compute_start;
    logic read;
    logic calc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_cell;
  } status_t;

endpackage

// ===== src/lcs3_ctrl.sv =====
// Controller state machine sequencing appends, cell walk and result strobe.
module lcs3_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  lcs3_pkg::action_e action_i,
  input  lcs3_pkg::status_t status_i,
  output lcs3_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              result_valid_o
);
  import lcs3_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_COMPUTE)) begin
          state_d = status_i.empty ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = status_i.last_cell ? ST_EMIT : ST_READ;
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.append        = accept && (action_i != ACT_COMPUTE);
        cmd_o.compute_start = accept && (action_i == ACT_COMPUTE);
      end
      ST_READ: cmd_o.read = 1'b1;
      ST_CALC: cmd_o.calc = 1'b1;
      ST_EMIT: cmd_o.emit = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_EMIT);

endmodule

// ===== src/lcs3_datapath.sv =====
// Datapath: sequence stores, two-plane cell memory, cell update and counters.
module lcs3_datapath #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcs3_pkg::cmd_t    cmd_i,
  input  lcs3_pkg::item_t   item_i,
  output lcs3_pkg::status_t status_o,
  output lcs3_pkg::result_t result_o
);
  import lcs3_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_LEN + 1);
  localparam int unsigned IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DEPTH = MAX_LEN * MAX_LEN;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [ElemW-1:0] seq_a_mem [MAX_LEN];
  logic signed [ElemW-1:0] seq_b_mem [MAX_LEN];
  logic signed [ElemW-1:0] seq_c_mem [MAX_LEN];
  // Each entry holds {plane newer, plane older} for one (j, k) cell.
  logic [2*CW-1:0]         plane_mem [DEPTH];

  logic [CW-1:0] cnt_a_q, cnt_b_q, cnt_c_q;
  logic          ovf_q;
  logic [CW-1:0] i_q, j_q, k_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] len_q;

  logic signed [ElemW-1:0] ea_q, eb_q, ec_q;
  logic [2*CW-1:0]         pa_q, pu_q;
  logic [CW-1:0]           cur_left_q, prev_left_q, prev_ul_q, cur_ul_q;

  logic [CW-1:0] i_m1, j_m1, k_m1;
  logic [AW-1:0] up_addr;
  logic          first_plane, first_row, first_col, match;
  logic [CW-1:0] p_jk, c_up, p_up, c_left, p_left, p_ul, c_ul, diag, best;
  logic          k_end, j_end, i_end;
  logic [CW-1:0] full_cnt;

  assign full_cnt = CW'(MAX_LEN);
  assign i_m1     = i_q - CW'(1);
  assign j_m1     = j_q - CW'(1);
  assign k_m1     = k_q - CW'(1);
  assign up_addr  = (j_q == CW'(1)) ? addr_q : (addr_q - AW'(cnt_c_q));

  assign first_plane = (i_q == CW'(1));
  assign first_row   = (j_q == CW'(1));
  assign first_col   = (k_q == CW'(1));
  assign match       = (ea_q == eb_q) && (eb_q == ec_q);

  assign p_jk   = first_plane ? '0 : pa_q[2*CW-1:CW];
  assign c_up   = first_row ? '0 : pu_q[2*CW-1:CW];
  assign p_up   = (first_row || first_plane) ? '0 : pu_q[CW-1:0];
  assign c_left = first_col ? '0 : cur_left_q;
  assign p_left = first_col ? '0 : prev_left_q;
  assign p_ul   = first_col ? '0 : prev_ul_q;
  assign c_ul   = first_col ? '0 : cur_ul_q;
  assign diag   = match ? (p_ul + CW'(1)) : p_ul;

  always_comb begin
    best = diag;
    if (c_up   > best) best = c_up;
    if (c_left > best) best = c_left;
    if (c_ul   > best) best = c_ul;
    if (p_jk   > best) best = p_jk;
    if (p_up   > best) best = p_up;
    if (p_left > best) best = p_left;
  end

  assign k_end = (k_q == cnt_c_q);
  assign j_end = (j_q == cnt_b_q);
  assign i_end = (i_q == cnt_a_q);

  assign status_o.empty     = (cnt_a_q == '0) || (cnt_b_q == '0) || (cnt_c_q == '0);
  assign status_o.last_cell = i_end && j_end && k_end;

  assign result_o.lcs_length = LenW'(len_q);
  assign result_o.overflow   = ovf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      case (item_i.action)
        ACT_APPEND_A: if (cnt_a_q != full_cnt) seq_a_mem[cnt_a_q[IW-1:0]] <= item_i.element_value;
        ACT_APPEND_B: if (cnt_b_q != full_cnt) seq_b_mem[cnt_b_q[IW-1:0]] <= item_i.element_value;
        ACT_APPEND_C: if (cnt_c_q != full_cnt) seq_c_mem[cnt_c_q[IW-1:0]] <= item_i.element_value;
        default: ;
      endcase
    end
    if (cmd_i.read) begin
      ea_q <= seq_a_mem[i_m1[IW-1:0]];
      eb_q <= seq_b_mem[j_m1[IW-1:0]];
      ec_q <= seq_c_mem[k_m1[IW-1:0]];
      pa_q <= plane_mem[addr_q];
      pu_q <= plane_mem[up_addr];
    end
    if (cmd_i.calc) begin
      plane_mem[addr_q] <= {best, p_jk};
      cur_left_q        <= best;
      prev_left_q       <= p_jk;
      prev_ul_q         <= p_up;
      cur_ul_q          <= c_up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      cnt_c_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= CW'(1);
      j_q     <= CW'(1);
      k_q     <= CW'(1);
      addr_q  <= '0;
      len_q   <= '0;
    end else begin
      if (cmd_i.append) begin
        case (item_i.action)
          ACT_APPEND_A: if (cnt_a_q == full_cnt) ovf_q <= 1'b1; else cnt_a_q <= cnt_a_q + CW'(1);
          ACT_APPEND_B: if (cnt_b_q == full_cnt) ovf_q <= 1'b1; else cnt_b_q <= cnt_b_q + CW'(1);
          ACT_APPEND_C: if (cnt_c_q == full_cnt) ovf_q <= 1'b1; else cnt_c_q <= cnt_c_q + CW'(1);
          default: ;
        endcase
      end
      if (cmd_i.compute_start) begin
        i_q    <= CW'(1);
        j_q    <= CW'(1);
        k_q    <= CW'(1);
        addr_q <= '0;
        len_q  <= '0;
      end
      if (cmd_i.calc) begin
        if (status_o.last_cell) begin
          len_q <= best;
        end
        if (!k_end) begin
          k_q    <= k_q + CW'(1);
          addr_q <= addr_q + AW'(1);
        end else begin
          k_q <= CW'(1);
          if (!j_end) begin
            j_q    <= j_q + CW'(1);
            addr_q <= addr_q + AW'(1);
          end else begin
            j_q    <= CW'(1);
            i_q    <= i_q + CW'(1);
            addr_q <= '0;
          end
        end
      end
      if (cmd_i.emit) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        cnt_c_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

endmodule

// ===== src/lcs3_three_sequence_length_unit.sv =====
// Top level of the three-sequence LCS length unit.
//
// Usage: drive item_i and raise start; a transaction is taken at a rising edge
// with start high and busy low. Actions 0..2 append element_value to sequence
// A, B or C and give no result; busy stays low, so appends may follow back to
// back. An append to a full sequence (MAX_LEN elements) is dropped and flags
// overflow in the next result.
// Action 3 computes: busy rises and the unit walks every cell of the
// na x nb x nc table, each cell by a plane memory read (ST_READ), then update
// and write back (ST_CALC). result_valid_o pulses for one cycle in ST_EMIT,
// after the last cell's update (in the cycle after the compute transaction if
// any sequence is empty), with result_o holding lcs_length and overflow; busy
// falls in the next cycle and all sequences and the overflow flag are cleared.
// No new transaction is taken until the result has been emitted.
// The receiver cannot stall: the result is valid for that one cycle only.
// Reset clears the counts, the flag and the controller; stores need no clear.
module lcs_three_sequence_length_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  lcs3_pkg::item_t   item_i,
  output logic              busy,
  output logic              result_valid_o,
  output lcs3_pkg::result_t result_o
);
  import lcs3_pkg::*;

  cmd_t    cmd;
  status_t status;

  lcs3_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .action_i       (item_i.action),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  lcs3_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .status_o (status),
    .result_o (result_o)
  );

  a_strobe_single : assert property (
    @(posedge clk_i) disable iff (!rst_ni) result_valid_o |=> !result_valid_o
  ) else $error("result strobe longer than one cycle");

  a_compute_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && (item_i.action == ACT_COMPUTE)) |=> busy
  ) else $error("compute transaction did not raise busy");

  a_append_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && (item_i.action != ACT_COMPUTE)) |=> (!busy && !result_valid_o)
  ) else $error("append transaction disturbed the controller");

  a_calc_after_read : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.read |=> cmd.calc
  ) else $error("cell update did not follow memory read");

endmodule
